// File: rtl/core/mrt_pkg.sv
// ----------------------------------------------------------------------------
// mrt_pkg
// Shared constants and types of the 4x4 matrix row transform core.
// ----------------------------------------------------------------------------
package mrt_pkg;

    localparam int ELEM_WIDTH      = 32;
    localparam int FRAC_BITS       = 16;
    localparam int FIELD_WIDTH     = 32;
    localparam int NUM_ROWS        = 4;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 64;

    typedef enum logic
    {
        OP_POINT = 1'b0,
        OP_ROW   = 1'b1
    } op_t;

    // control that travels with every request through the chain
    typedef struct packed
    {
        logic valid;
        op_t  op;
    } ctrl_t;

endpackage

// File: rtl/core/mrt_cell.sv
// ----------------------------------------------------------------------------
// mrt_cell
// One matrix row: holds four coefficients, multiplies its element by them
// and adds the truncated products onto the running column sums.
// ----------------------------------------------------------------------------
module mrt_cell #(
    parameter int ELEM_WIDTH = mrt_pkg::ELEM_WIDTH,
    parameter int FRAC_BITS  = mrt_pkg::FRAC_BITS,
    parameter int ROW        = 0
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mrt_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [mrt_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    input  mrt_pkg::ctrl_t                        in_ctrl,
    output logic                                  in_ready,
    input  logic [3:0][ELEM_WIDTH-1:0]            in_elem,
    input  logic [3:0][2*ELEM_WIDTH-FRAC_BITS+((ELEM_WIDTH>ELEM_WIDTH-FRAC_BITS+ELEM_WIDTH)
                      ? 0 : 0)+((ELEM_WIDTH > 2*ELEM_WIDTH-FRAC_BITS)
                      ? FRAC_BITS-ELEM_WIDTH : 0)+1:0] in_acc,
    output mrt_pkg::ctrl_t                        out_ctrl,
    input  logic                                  out_ready,
    output logic [3:0][ELEM_WIDTH-1:0]            out_elem,
    output logic [3:0][2*ELEM_WIDTH-FRAC_BITS+((ELEM_WIDTH>ELEM_WIDTH-FRAC_BITS+ELEM_WIDTH)
                      ? 0 : 0)+((ELEM_WIDTH > 2*ELEM_WIDTH-FRAC_BITS)
                      ? FRAC_BITS-ELEM_WIDTH : 0)+1:0] out_acc
);

    localparam int PW = 2*ELEM_WIDTH - FRAC_BITS;
    localparam int TW = (PW > ELEM_WIDTH) ? PW : ELEM_WIDTH;
    localparam int AW = TW + 2;
    localparam int HW = mrt_pkg::CFG_DATA_WIDTH / 2;
    localparam logic [HW-1:0] ONE_W = HW'(1) << FRAC_BITS;

    logic [3:0][ELEM_WIDTH-1:0]   coef_reg;

    mrt_pkg::ctrl_t               a_ctrl_reg;
    logic [3:0][ELEM_WIDTH-1:0]   a_elem_reg;
    logic [3:0][AW-1:0]           a_acc_reg;
    logic [3:0][2*ELEM_WIDTH-1:0] a_prod_reg;
    logic [3:0][2*ELEM_WIDTH-1:0] a_prod_next;

    mrt_pkg::ctrl_t               b_ctrl_reg;
    logic [3:0][ELEM_WIDTH-1:0]   b_elem_reg;
    logic [3:0][AW-1:0]           b_acc_reg;
    logic [3:0][AW-1:0]           b_acc_next;

    logic                         a_ready;
    logic                         b_ready;

    // coefficient registers of this row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 4; c++)
            begin
                coef_reg[c] <= (c == ROW) ? ONE_W[ELEM_WIDTH-1:0] : '0;
            end
        end
        else if (cfg_we && (cfg_index[2:1] == 2'(ROW)))
        begin
            if (cfg_index[0])
            begin
                coef_reg[2] <= cfg_data[ELEM_WIDTH-1:0];
                coef_reg[3] <= cfg_data[HW+ELEM_WIDTH-1:HW];
            end
            else
            begin
                coef_reg[0] <= cfg_data[ELEM_WIDTH-1:0];
                coef_reg[1] <= cfg_data[HW+ELEM_WIDTH-1:HW];
            end
        end
    end

    assign b_ready  = !b_ctrl_reg.valid || out_ready;
    assign a_ready  = !a_ctrl_reg.valid || b_ready;
    assign in_ready = a_ready;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            a_prod_next[c] = $signed(in_elem[ROW]) * $signed(coef_reg[c]);
        end
    end

    always_comb
    begin
        logic [AW-1:0] term;
        term = '0;
        for (int c = 0; c < 4; c++)
        begin
            // a point uses w = 1, so the last row adds its coefficient as it is
            if ((ROW == 3) && (a_ctrl_reg.op == mrt_pkg::OP_POINT))
            begin
                term = {{(AW-ELEM_WIDTH){coef_reg[c][ELEM_WIDTH-1]}}, coef_reg[c]};
            end
            else
            begin
                term = {{(AW-PW){a_prod_reg[c][2*ELEM_WIDTH-1]}},
                        a_prod_reg[c][2*ELEM_WIDTH-1:FRAC_BITS]};
            end
            b_acc_next[c] = a_acc_reg[c] + term;
        end
    end

    // multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctrl_reg <= '0;
        end
        else if (a_ready)
        begin
            a_ctrl_reg <= in_ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_ctrl.valid)
        begin
            a_elem_reg <= in_elem;
            a_acc_reg  <= in_acc;
            a_prod_reg <= a_prod_next;
        end
    end

    // accumulate stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_ctrl_reg <= '0;
        end
        else if (b_ready)
        begin
            b_ctrl_reg <= a_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_ctrl_reg.valid)
        begin
            b_elem_reg <= a_elem_reg;
            b_acc_reg  <= b_acc_next;
        end
    end

    assign out_ctrl = b_ctrl_reg;
    assign out_elem = b_elem_reg;
    assign out_acc  = b_acc_reg;

endmodule

// File: rtl/core/mrt_sat.sv
// ----------------------------------------------------------------------------
// mrt_sat
// Clamps the four column sums to the element range, sets the saturation
// flag and holds the result in the output register.
// ----------------------------------------------------------------------------
module mrt_sat #(
    parameter int ELEM_WIDTH = mrt_pkg::ELEM_WIDTH,
    parameter int FRAC_BITS  = mrt_pkg::FRAC_BITS
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  mrt_pkg::ctrl_t                            in_ctrl,
    output logic                                      in_ready,
    input  logic [3:0][2*ELEM_WIDTH-FRAC_BITS+((ELEM_WIDTH>ELEM_WIDTH-FRAC_BITS+ELEM_WIDTH)
                      ? 0 : 0)+((ELEM_WIDTH > 2*ELEM_WIDTH-FRAC_BITS)
                      ? FRAC_BITS-ELEM_WIDTH : 0)+1:0] in_acc,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic [3:0][mrt_pkg::FIELD_WIDTH-1:0]      out_res,
    output logic                                      out_sat
);

    localparam int PW = 2*ELEM_WIDTH - FRAC_BITS;
    localparam int TW = (PW > ELEM_WIDTH) ? PW : ELEM_WIDTH;
    localparam int AW = TW + 2;
    localparam int FW = mrt_pkg::FIELD_WIDTH;

    logic                        valid_reg;
    logic [3:0][FW-1:0]          res_reg;
    logic                        sat_reg;
    logic [3:0][FW-1:0]          res_next;
    logic                        sat_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        logic                  over;
        logic                  under;
        logic [ELEM_WIDTH-1:0] clamped;
        over     = 1'b0;
        under    = 1'b0;
        clamped  = '0;
        sat_next = 1'b0;
        for (int c = 0; c < 4; c++)
        begin
            over  = !in_acc[c][AW-1] && (|in_acc[c][AW-2:ELEM_WIDTH-1]);
            under = in_acc[c][AW-1] && !(&in_acc[c][AW-2:ELEM_WIDTH-1]);
            if (over)
            begin
                clamped = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
            end
            else if (under)
            begin
                clamped = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
            end
            else
            begin
                clamped = in_acc[c][ELEM_WIDTH-1:0];
            end
            // the w column of a point is forced to zero and never flags
            if ((c == 3) && (in_ctrl.op == mrt_pkg::OP_POINT))
            begin
                res_next[c] = '0;
            end
            else
            begin
                res_next[c] = FW'($signed(clamped));
                sat_next    = sat_next | over | under;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_ctrl.valid)
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_sat   = sat_reg;

endmodule

// File: rtl/core/matrix_row_transform_core.sv
// ----------------------------------------------------------------------------
// matrix_row_transform_core
// Row vector times a configured 4x4 fixed point matrix, one row per cell.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request per element row: tdata holds x, y, z, w and
//   tuser the opcode (point transform with w taken as one, or full row).
//   m_* returns one result per request: tdata holds the four clamped
//   columns (w is zero for a point) and tuser the saturation flag.
//   cfg_we / cfg_index / cfg_data write the matrix, two coefficients per register; the
//   user must do so only while no request is in flight: the block does not enforce it.
// Timing:
//   A request passes nine register stages: four row cells of two each
//   (multiply, then accumulate) and the clamp register, the first loaded
//   at the accept. Throughput is one request per cycle while m_tready
//   is high; a stall holds the cell chain as described below.
// Reset:
//   The matrix returns to identity and all stages are emptied.
// Stall:
//   When m_tready is low the result holds, the stages behind it keep
//   filling up bubbles, and s_tready drops only once every stage is full.
// ----------------------------------------------------------------------------
module matrix_row_transform_core #(
    parameter int ELEM_WIDTH = mrt_pkg::ELEM_WIDTH,
    parameter int FRAC_BITS  = mrt_pkg::FRAC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_we,
    input  logic [mrt_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [mrt_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    // request side
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [4*mrt_pkg::FIELD_WIDTH-1:0]    s_tdata,  // elem_x, elem_y, elem_z, elem_w
    input  logic                                 s_tuser,  // opcode
    // result side
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [4*mrt_pkg::FIELD_WIDTH-1:0]    m_tdata,  // res_x, res_y, res_z, res_w
    output logic                                 m_tuser   // saturated
);

    localparam int PW = 2*ELEM_WIDTH - FRAC_BITS;
    localparam int TW = (PW > ELEM_WIDTH) ? PW : ELEM_WIDTH;
    localparam int AW = TW + 2;
    localparam int FW = mrt_pkg::FIELD_WIDTH;
    localparam int NR = mrt_pkg::NUM_ROWS;

    mrt_pkg::ctrl_t              ctrl_chain  [NR+1];
    logic                        ready_chain [NR+1];
    logic [3:0][ELEM_WIDTH-1:0]  elem_chain  [NR+1];
    logic [3:0][AW-1:0]          acc_chain   [NR+1];
    logic [3:0][FW-1:0]          res;

    assign ctrl_chain[0].valid = s_tvalid;
    assign ctrl_chain[0].op    = mrt_pkg::op_t'(s_tuser);
    assign s_tready            = ready_chain[0];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            elem_chain[0][k] = s_tdata[k*FW +: ELEM_WIDTH];
        end
    end

    assign acc_chain[0] = '0;

    for (genvar r = 0; r < NR; r++)
    begin : g_row
        mrt_cell #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .FRAC_BITS  (FRAC_BITS),
            .ROW        (r)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cfg_we     (cfg_we),
            .cfg_index  (cfg_index),
            .cfg_data   (cfg_data),
            .in_ctrl    (ctrl_chain[r]),
            .in_ready   (ready_chain[r]),
            .in_elem    (elem_chain[r]),
            .in_acc     (acc_chain[r]),
            .out_ctrl   (ctrl_chain[r+1]),
            .out_ready  (ready_chain[r+1]),
            .out_elem   (elem_chain[r+1]),
            .out_acc    (acc_chain[r+1])
        );
    end

    mrt_sat #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_sat (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ctrl    (ctrl_chain[NR]),
        .in_ready   (ready_chain[NR]),
        .in_acc     (acc_chain[NR]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (res),
        .out_sat    (m_tuser)
    );

    assign m_tdata = res;

endmodule

// File: verif/matrix_row_transform_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_row_transform_core_test
// Self-checking bench for the 4x4 fixed point row transform core.
// A queue of element rows feeds a stream driver. Every accepted request is
// run through a local Q16.16 model of the matrix product, and its expected
// result is queued. The monitor checks each returned result against that
// queue, field by field. The matrix is rewritten between phases while the
// core is drained. Both sides insert random stall bursts in phases where
// idle_en is set, which excludes the last phase and, at random, some others.
// ----------------------------------------------------------------------------
module matrix_row_transform_core_test;

    typedef mrt_pkg::op_t op_t;

    localparam int  ELEM_WIDTH      = mrt_pkg::ELEM_WIDTH;
    localparam int  FRAC_BITS       = mrt_pkg::FRAC_BITS;
    localparam int  FIELD_WIDTH     = mrt_pkg::FIELD_WIDTH;
    localparam int  CFG_INDEX_WIDTH = mrt_pkg::CFG_INDEX_WIDTH;
    localparam int  CFG_DATA_WIDTH  = mrt_pkg::CFG_DATA_WIDTH;
    localparam op_t OP_POINT        = mrt_pkg::OP_POINT;
    localparam op_t OP_ROW          = mrt_pkg::OP_ROW;

    localparam int REG_COUNT      = 8;
    localparam int IDLE_MAX       = 14;
    localparam int LATENCY        = 9;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 8;
    localparam int ROWS_PER_PHASE = 100;

    typedef enum int
    {
        REG_ROW0_COLS01 = 0,
        REG_ROW0_COLS23 = 1,
        REG_ROW1_COLS01 = 2,
        REG_ROW1_COLS23 = 3,
        REG_ROW2_COLS01 = 4,
        REG_ROW2_COLS23 = 5,
        REG_ROW3_COLS01 = 6,
        REG_ROW3_COLS23 = 7
    } reg_index_t;

    typedef struct packed
    {
        op_t              op;
        logic [3:0][31:0] elem;   // x in elem[0]
    } row_req_t;

    typedef struct packed
    {
        logic             sat;
        logic [3:0][31:0] res;    // res_x in res[0]
    } row_res_t;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               cfg_we    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0]         cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]          cfg_data  = '0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [4*FIELD_WIDTH-1:0]           s_tdata   = '0;  // elem_x, elem_y, elem_z, elem_w
    logic                               s_tuser   = 1'b0; // opcode
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [4*FIELD_WIDTH-1:0]           m_tdata;          // res_x, res_y, res_z, res_w
    logic                               m_tuser;          // saturated

    logic [63:0] matrix_regs [REG_COUNT];
    logic [63:0] staged_regs [REG_COUNT];

    row_req_t pending_rows [$];
    row_res_t expected_rows [$];
    row_req_t cur_row;

    bit idle_en       = 1'b1;
    int send_gap      = 0;
    int stall_left    = 0;
    int mismatch_cnt  = 0;
    int quiet_cycles  = 0;

    matrix_row_transform_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // coefficient M[r][c]: even column in the low half, odd in the high half
    function automatic longint coef_at(int r, int c);
        logic [63:0] word;
        logic [31:0] half;
        word = matrix_regs[r * 2 + c / 2];
        half = (c % 2 != 0) ? word[63:32] : word[31:0];
        return longint'(signed'(half));
    endfunction

    function automatic row_res_t transform_row(row_req_t rq);
        row_res_t rs;
        longint   acc;
        longint   lim_hi;
        longint   lim_lo;
        lim_hi = (longint'(1) <<< (ELEM_WIDTH - 1)) - 1;
        lim_lo = -(longint'(1) <<< (ELEM_WIDTH - 1));
        rs     = '0;
        for (int c = 0; c < 4; c++)
        begin
            if (rq.op == OP_POINT && c == 3)
            begin
                rs.res[c] = '0;
            end
            else
            begin
                acc = 0;
                // products truncate toward minus infinity
                for (int k = 0; k < 3; k++)
                    acc += (longint'(signed'(rq.elem[k])) * coef_at(k, c)) >>> FRAC_BITS;
                if (rq.op == OP_POINT)
                    acc += coef_at(3, c);
                else
                    acc += (longint'(signed'(rq.elem[3])) * coef_at(3, c)) >>> FRAC_BITS;
                if (acc > lim_hi)
                begin
                    acc    = lim_hi;
                    rs.sat = 1'b1;
                end
                else if (acc < lim_lo)
                begin
                    acc    = lim_lo;
                    rs.sat = 1'b1;
                end
                rs.res[c] = acc[31:0];
            end
        end
        return rs;
    endfunction

    function automatic void queue_row(op_t op, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z, logic [31:0] w);
        row_req_t rq;
        rq.op   = op;
        rq.elem = {w, z, y, x};
        pending_rows.push_back(rq);
    endfunction

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    // mostly within +-16.0 so that many sums stay in range
    function automatic logic [31:0] random_elem();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return pick_extreme();
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    // mostly within +-4.0
    function automatic logic [31:0] random_coef();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return pick_extreme();
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    task automatic program_matrix();
        for (int i = 0; i < REG_COUNT; i++)
        begin
            @(posedge clk);
            cfg_we         <= 1'b1;
            cfg_index      <= CFG_INDEX_WIDTH'(i);
            cfg_data       <= staged_regs[i];
            matrix_regs[i]  = staged_regs[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // wait until every request has been answered
    task automatic drain();
        @(negedge clk);
        while (pending_rows.size() != 0 || expected_rows.size() != 0 || s_tvalid)
            @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_rows.push_back(transform_row(cur_row));
            if (s_tvalid && !s_tready)
            begin
                // hold the request
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_rows.size() != 0)
            begin
                cur_row   = pending_rows.pop_front();
                s_tdata  <= cur_row.elem;
                s_tuser  <= cur_row.op;
                s_tvalid <= 1'b1;
                if (idle_en && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, IDLE_MAX);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side back pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, IDLE_MAX) - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        row_res_t got;
        row_res_t want;
        bit       bad;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.res = m_tdata;
            got.sat = m_tuser;
            if (expected_rows.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected result x=%0d y=%0d z=%0d w=%0d sat=%0b",
                             $signed(got.res[0]), $signed(got.res[1]),
                             $signed(got.res[2]), $signed(got.res[3]), got.sat);
            end
            else
            begin
                want = expected_rows.pop_front();
                bad  = (got.sat !== want.sat);
                for (int c = 0; c < 4; c++)
                    if (got.res[c] !== want.res[c])
                        bad = 1'b1;
                if (bad)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                    begin
                        $display("mismatch: exp x=%0d y=%0d z=%0d w=%0d sat=%0b",
                                 $signed(want.res[0]), $signed(want.res[1]),
                                 $signed(want.res[2]), $signed(want.res[3]), want.sat);
                        $display("          got x=%0d y=%0d z=%0d w=%0d sat=%0b",
                                 $signed(got.res[0]), $signed(got.res[1]),
                                 $signed(got.res[2]), $signed(got.res[3]), got.sat);
                    end
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        // identity after reset
        for (int i = 0; i < REG_COUNT; i++)
            matrix_regs[i] = '0;
        matrix_regs[REG_ROW0_COLS01] = 64'h0000_0000_0001_0000;
        matrix_regs[REG_ROW1_COLS01] = 64'h0001_0000_0000_0000;
        matrix_regs[REG_ROW2_COLS23] = 64'h0000_0000_0001_0000;
        matrix_regs[REG_ROW3_COLS23] = 64'h0001_0000_0000_0000;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // identity: values pass through, w ignored for a point
        queue_row(OP_POINT, 32'h0, 32'h0, 32'h0, 32'h1234_5678);
        queue_row(OP_ROW,   32'h0, 32'h0, 32'h0, 32'h0);
        queue_row(OP_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_row(OP_ROW,   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_row(OP_ROW,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_row(OP_POINT, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_row(OP_ROW,   32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        drain();

        // largest coefficients everywhere: positive and negative overflow
        for (int i = 0; i < REG_COUNT; i++)
            staged_regs[i] = 64'h7FFF_FFFF_7FFF_FFFF;
        program_matrix();
        queue_row(OP_ROW,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_row(OP_ROW,   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_row(OP_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
        queue_row(OP_POINT, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF);
        queue_row(OP_ROW,   32'h1, 32'h1, 32'h1, 32'h1);
        queue_row(OP_ROW,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // most negative coefficients; translation lands exactly on the bound
        for (int i = 0; i < REG_COUNT; i++)
            staged_regs[i] = 64'h8000_0000_8000_0000;
        program_matrix();
        queue_row(OP_ROW,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_row(OP_ROW,   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_row(OP_POINT, 32'h0, 32'h0, 32'h0, 32'h0);
        queue_row(OP_ROW,   32'h1, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF);
        drain();

        // scale by 2.0 with translation (1.5, -2.5, 3.0)
        for (int i = 0; i < REG_COUNT; i++)
            staged_regs[i] = '0;
        staged_regs[REG_ROW0_COLS01] = 64'h0000_0000_0002_0000;
        staged_regs[REG_ROW1_COLS01] = 64'h0002_0000_0000_0000;
        staged_regs[REG_ROW2_COLS23] = 64'h0000_0000_0002_0000;
        staged_regs[REG_ROW3_COLS01] = 64'hFFFD_8000_0001_8000;
        staged_regs[REG_ROW3_COLS23] = 64'h0001_0000_0003_0000;
        program_matrix();
        queue_row(OP_POINT, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'hDEAD_BEEF);
        queue_row(OP_POINT, 32'h3FFF_FFFF, 32'hC000_0000, 32'h0, 32'h0);
        queue_row(OP_ROW,   32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                staged_regs[i] = {random_coef(), random_coef()};
            program_matrix();
            idle_en = (phase != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < ROWS_PER_PHASE; n++)
                queue_row(op_t'($urandom_range(0, 1)), random_elem(), random_elem(),
                          random_elem(), random_elem());
            drain();
        end

        repeat (2 * LATENCY) @(posedge clk);
        if (mismatch_cnt == 0 && expected_rows.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
